[hdl/red_pkg.sv]
package red_pkg;

  // Fixed-point layout of the average: 13 integer bits, 16 fraction bits.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned AVG_W     = LEN_W + FRAC_BITS;
  localparam int unsigned PROB_W    = 16;

  // Occupancy above this is clamped before it enters the average.
  localparam logic [LEN_W-1:0] QUEUE_DEPTH = 13'd4096;

  // Saturation value of the count-plus-one register.
  localparam logic [PROB_W-1:0] COUNT_SAT = 16'hFFFF;

  // Probability one in Q0.16, as a 17-bit value.
  localparam logic [PROB_W:0] PROB_ONE = 17'h10000;

  // Long division of the band probability: one quotient bit per step.
  localparam int unsigned DIV_STEPS = PROB_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_A_W = PROB_W + 1;
  localparam int unsigned MUL_B_W = AVG_W;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_QUEUE_CAPACITY  = 3'd0;
  localparam logic [2:0] REG_WEIGHT_SHIFT    = 3'd1;
  localparam logic [2:0] REG_MIN_THRESHOLD   = 3'd2;
  localparam logic [2:0] REG_MAX_THRESHOLD   = 3'd3;
  localparam logic [2:0] REG_MAX_PROBABILITY = 3'd4;
  localparam logic [2:0] REG_ECN_ENABLE      = 3'd5;

  typedef enum logic [1:0] {
    VERDICT_ENQUEUE     = 2'd0,
    VERDICT_MARKED      = 2'd1,
    VERDICT_EARLY_DROP  = 2'd2,
    VERDICT_FORCED_DROP = 2'd3
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_CLASS,
    ST_MUL1,
    ST_DIV,
    ST_MUL2,
    ST_MUL3,
    ST_DEC,
    ST_OUT
  } state_t;

endpackage

[hdl/red_enqueue_decision.sv]
// RED enqueue decision for one queue.
// Each input transaction on in_* carries the current queue length and a random
// word; the block answers with one output transaction on out_* holding the
// verdict (enqueue, enqueue with ECN mark, early drop, forced drop) and the
// integer part of the updated average queue length.
// The cfg_* channel writes the six configuration registers; it is always ready
// and should be used only while no arrival is in flight.
// One arrival is processed at a time and in_tready is high only while the
// sequencer is idle. A forced drop goes from ST_AVG to ST_OUT and an average
// outside the marking band goes through ST_CLASS to ST_OUT; an average inside
// the band also passes the 16-step shift-subtract divider that forms the band
// probability and makes three passes through the shared 17x29 multiplier.
// The result sits in an output register, so the next arrival is accepted while
// it waits; if the receiver stalls, the following result waits in the
// sequencer until the output register is free.
// Reset (rst_n low, synchronous) clears the average to zero, the count to
// minus one, the output valid flag, and loads the default register values.
module red_enqueue_decision (
  input  logic        clk,
  input  logic        rst_n,
  // Input: [12:0] queue_length, [28:13] random_word, [31:29] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // Output: [1:0] verdict, [14:2] average_length, [15] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import red_pkg::*;

  // Configuration registers
  logic [LEN_W-1:0]  queue_capacity_r;
  logic [3:0]        weight_shift_r;
  logic [LEN_W-1:0]  min_threshold_r;
  logic [LEN_W-1:0]  max_threshold_r;
  logic [PROB_W-1:0] max_probability_r;
  logic              ecn_enable_r;

  // Sequencer and persistent state
  state_t            state_r, state_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt;
  logic [PROB_W-1:0] cpo_r, cpo_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of one arrival
  logic [LEN_W-1:0]   qlen_r, qlen_nxt;
  logic [PROB_W-1:0]  rnd_r, rnd_nxt;
  verdict_t           verdict_r, verdict_nxt;
  logic [AVG_W-1:0]   rem_r, rem_nxt;
  logic [PROB_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [MUL_P_W-1:0] prod_r, prod_nxt;
  logic               certain_r, certain_nxt;
  logic [15:0]        out_data_r, out_data_nxt;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  // Combinational helpers
  logic [LEN_W-1:0] q_sat;
  logic [AVG_W-1:0] avg_upd;
  logic [AVG_W-1:0] hi_w, lo_w, span_w;
  logic [AVG_W:0]   div_shift;
  logic [AVG_W:0]   div_diff;
  verdict_t         mark_verdict;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_capacity_r  <= 13'd4096;
      weight_shift_r    <= 4'd9;
      min_threshold_r   <= 13'd5;
      max_threshold_r   <= 13'd15;
      max_probability_r <= 16'd6554;
      ecn_enable_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QUEUE_CAPACITY:  queue_capacity_r  <= cfg_data[LEN_W-1:0];
        REG_WEIGHT_SHIFT:    weight_shift_r    <= cfg_data[3:0];
        REG_MIN_THRESHOLD:   min_threshold_r   <= cfg_data[LEN_W-1:0];
        REG_MAX_THRESHOLD:   max_threshold_r   <= cfg_data[LEN_W-1:0];
        REG_MAX_PROBABILITY: max_probability_r <= cfg_data;
        REG_ECN_ENABLE:      ecn_enable_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Average update: avg - (avg >> s) + ((q << 16) >> s), q clamped to the depth.
  assign q_sat   = (qlen_r > QUEUE_DEPTH) ? QUEUE_DEPTH : qlen_r;
  assign avg_upd = avg_r - (avg_r >> weight_shift_r)
                   + ({q_sat, {FRAC_BITS{1'b0}}} >> weight_shift_r);

  // Thresholds in the fixed-point format of the average.
  assign hi_w   = {max_threshold_r, {FRAC_BITS{1'b0}}};
  assign lo_w   = {min_threshold_r, {FRAC_BITS{1'b0}}};
  assign span_w = {max_threshold_r - min_threshold_r, {FRAC_BITS{1'b0}}};

  // One step of the restoring divider.
  assign div_shift = {rem_r, quo_r[PROB_W-1]};
  assign div_diff  = div_shift - {1'b0, span_w};

  assign mark_verdict = ecn_enable_r ? VERDICT_MARKED : VERDICT_EARLY_DROP;

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    cpo_nxt       = cpo_r;
    qlen_nxt      = qlen_r;
    rnd_nxt       = rnd_r;
    verdict_nxt   = verdict_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    prod_nxt      = prod_r;
    certain_nxt   = certain_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_a         = '0;
    mul_b         = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          qlen_nxt  = in_tdata[LEN_W-1:0];
          rnd_nxt   = in_tdata[LEN_W+PROB_W-1:LEN_W];
          state_nxt = ST_AVG;
        end
      end

      // Forced drop leaves the average alone; otherwise fold in the sample.
      ST_AVG: begin
        if (qlen_r >= queue_capacity_r) begin
          verdict_nxt = VERDICT_FORCED_DROP;
          cpo_nxt     = '0;
          state_nxt   = ST_OUT;
        end else begin
          avg_nxt   = avg_upd;
          state_nxt = ST_CLASS;
        end
      end

      // Place the new average against the band.
      ST_CLASS: begin
        if (avg_r > hi_w) begin
          verdict_nxt = mark_verdict;
          cpo_nxt     = 16'd1;
          state_nxt   = ST_OUT;
        end else if (avg_r > lo_w) begin
          cpo_nxt   = (cpo_r != COUNT_SAT) ? cpo_r + 16'd1 : cpo_r;
          state_nxt = ST_MUL1;
        end else begin
          verdict_nxt = VERDICT_ENQUEUE;
          cpo_nxt     = '0;
          state_nxt   = ST_OUT;
        end
      end

      // Numerator of p_b, loaded straight into the divider.
      ST_MUL1: begin
        mul_a     = {1'b0, max_probability_r};
        mul_b     = avg_r - lo_w;
        rem_nxt   = mul_p[AVG_W+PROB_W-1:PROB_W];
        quo_nxt   = mul_p[PROB_W-1:0];
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end

      // p_b = numerator / span, one quotient bit per cycle.
      ST_DIV: begin
        if (!div_diff[AVG_W]) begin
          rem_nxt = div_diff[AVG_W-1:0];
        end else begin
          rem_nxt = div_shift[AVG_W-1:0];
        end
        quo_nxt  = {quo_r[PROB_W-2:0], !div_diff[AVG_W]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          state_nxt = ST_MUL2;
        end
      end

      // count * p_b
      ST_MUL2: begin
        mul_a     = {1'b0, cpo_r - 16'd1};
        mul_b     = MUL_B_W'(quo_r);
        prod_nxt  = mul_p;
        state_nxt = ST_MUL3;
      end

      // random < floor(p_b * 2^16 / d) holds exactly when (random + 1) * d <= p_b * 2^16,
      // with d = 1 - count * p_b; a product of one or more makes the mark certain.
      ST_MUL3: begin
        certain_nxt = (prod_r[MUL_P_W-1:FRAC_BITS] != '0);
        mul_a       = {1'b0, rnd_r} + MUL_A_W'(1);
        mul_b       = MUL_B_W'(PROB_ONE - prod_r[PROB_W:0]);
        prod_nxt    = mul_p;
        state_nxt   = ST_DEC;
      end

      ST_DEC: begin
        if (certain_r || (prod_r <= MUL_P_W'({quo_r, {FRAC_BITS{1'b0}}}))) begin
          verdict_nxt = mark_verdict;
          cpo_nxt     = 16'd1;
        end else begin
          verdict_nxt = VERDICT_ENQUEUE;
        end
        state_nxt = ST_OUT;
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, avg_r[AVG_W-1:FRAC_BITS], verdict_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and the persistent average and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      avg_r       <= '0;
      cpo_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avg_r       <= avg_nxt;
      cpo_r       <= cpo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    qlen_r     <= qlen_nxt;
    rnd_r      <= rnd_nxt;
    verdict_r  <= verdict_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    prod_r     <= prod_nxt;
    certain_r  <= certain_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[tb/sv/red_enqueue_decision_tb.sv]
`timescale 1ns / 100ps

import red_pkg::*;

// One expected verdict and the average that goes with it.
typedef struct {
  verdict_t   verdict;
  bit [12:0]  avg_len;
} decision_t;

// Tracks the RED state on the testbench side and checks every output transaction.
class verdict_tracker;
  // Register copies.
  bit [12:0] capacity;
  bit [3:0]  shift;
  bit [12:0] min_th;
  bit [12:0] max_th;
  bit [15:0] max_p;
  bit        ecn;

  // Average in Q13.16, held wider so the update never overflows.
  bit [63:0] avg_fx;
  bit [15:0] count_p1;

  decision_t expected_verdicts[$];
  int errors;
  int band_hits;
  int verdict_seen[4];

  function new();
    capacity = 13'd4096;
    shift    = 4'd9;
    min_th   = 13'd5;
    max_th   = 13'd15;
    max_p    = 16'd6554;
    ecn      = 1'b0;
    avg_fx   = '0;
    count_p1 = '0;
    errors   = 0;
    band_hits = 0;
    foreach (verdict_seen[i]) verdict_seen[i] = 0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [15:0] data);
    case (idx)
      REG_QUEUE_CAPACITY:  capacity = data[12:0];
      REG_WEIGHT_SHIFT:    shift    = data[3:0];
      REG_MIN_THRESHOLD:   min_th   = data[12:0];
      REG_MAX_THRESHOLD:   max_th   = data[12:0];
      REG_MAX_PROBABILITY: max_p    = data[15:0];
      REG_ECN_ENABLE:      ecn      = data[0];
      default: ;
    endcase
  endfunction

  // Mark probability inside the band, spread by the count; Q0.16 with one meaning certain.
  function bit [63:0] spread_probability(bit [15:0] count);
    bit [63:0] lo_fx;
    bit [63:0] span;
    bit [63:0] pb;
    bit [63:0] prod;
    bit [63:0] pa;
    lo_fx = 64'(min_th) << FRAC_BITS;
    span  = (64'(max_th) - 64'(min_th)) << FRAC_BITS;
    pb    = (64'(max_p) * (avg_fx - lo_fx)) / span;
    prod  = 64'(count) * pb;
    if (prod >= 64'd65536) return 64'd65536;
    pa = (pb << FRAC_BITS) / (64'd65536 - prod);
    if (pa > 64'd65536) pa = 64'd65536;
    return pa;
  endfunction

  // Work out the verdict for one accepted arrival and queue it.
  function void note_arrival(bit [12:0] qlen, bit [15:0] rnd);
    verdict_t  v;
    verdict_t  mark;
    bit [63:0] q;
    bit [63:0] hi_fx;
    bit [63:0] lo_fx;
    bit [63:0] pa;
    decision_t d;
    v    = VERDICT_ENQUEUE;
    mark = ecn ? VERDICT_MARKED : VERDICT_EARLY_DROP;
    if (qlen >= capacity) begin
      // Forced drop holds the average and restarts the count.
      v = VERDICT_FORCED_DROP;
      count_p1 = '0;
    end else begin
      q = (qlen > QUEUE_DEPTH) ? 64'(QUEUE_DEPTH) : 64'(qlen);
      hi_fx = 64'(max_th) << FRAC_BITS;
      lo_fx = 64'(min_th) << FRAC_BITS;
      avg_fx = avg_fx - (avg_fx >> shift) + ((q << FRAC_BITS) >> shift);
      if (avg_fx > hi_fx) begin
        v = mark;
        count_p1 = 16'd1;
      end else if (avg_fx > lo_fx) begin
        band_hits++;
        if (count_p1 != COUNT_SAT) count_p1++;
        pa = spread_probability(count_p1 - 16'd1);
        if (64'(rnd) < pa) begin
          v = mark;
          count_p1 = 16'd1;
        end
      end else begin
        count_p1 = '0;
      end
    end
    d.verdict = v;
    d.avg_len = avg_fx[28:16];
    expected_verdicts.push_back(d);
  endfunction

  function void check_result(bit [15:0] data);
    decision_t want;
    if (expected_verdicts.size() == 0) begin
      $display("%0t: result with no arrival waiting: verdict %0d average %0d",
               $time, data[1:0], data[14:2]);
      errors++;
      return;
    end
    want = expected_verdicts.pop_front();
    verdict_seen[data[1:0]]++;
    if (data[1:0] != want.verdict) begin
      $display("%0t: verdict mismatch: expected %0d actual %0d",
               $time, want.verdict, data[1:0]);
      errors++;
    end
    if (data[14:2] != want.avg_len) begin
      $display("%0t: average length mismatch: expected %0d actual %0d",
               $time, want.avg_len, data[14:2]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_verdicts.size();
  endfunction
endclass

module red_enqueue_decision_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 40;

  // Indexes past the register list; writes there must have no effect.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    bit [12:0] capacity;
    bit [3:0]  shift;
    bit [12:0] min_th;
    bit [12:0] max_th;
    bit [15:0] max_p;
    bit        ecn;
  } red_settings_t;

  typedef struct packed {
    bit [15:0] rnd;
    bit [12:0] qlen;
  } arrival_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  verdict_tracker sb;
  arrival_t       arrival_q[$];
  bit             hold_request = 1'b0;
  int             items_sent   = 0;
  int             settings_used = 0;

  red_enqueue_decision uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: checks each output transaction and stalls in changing modes.
  initial begin
    int  mode;
    int  mode_left;
    int  stall_left;
    int  hold_left;
    bit  ready;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_result(out_tdata);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready = 1'b0;
      end else begin
        case (mode)
          0: ready = 1'b1;
          1: ready = ($urandom_range(0, 3) != 0);
          2: ready = ($urandom_range(0, 3) == 0);
          default: begin
            ready = 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 40);
          end
        endcase
      end
      out_tready <= ready;
    end
  end

  // Watchdog: ends the run when no transaction of any kind happens for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
          (out_tvalid === 1'b1 && out_tready === 1'b1) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired after %0d idle cycles, %0d results outstanding",
                 $time, idle_cycles, sb.pending());
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic red_settings_t make_settings(int cap, int sh, int mn, int mx,
                                                  int mp, int en);
    red_settings_t s;
    s.capacity = cap[12:0];
    s.shift    = sh[3:0];
    s.min_th   = mn[12:0];
    s.max_th   = mx[12:0];
    s.max_p    = mp[15:0];
    s.ecn      = en[0];
    return s;
  endfunction

  // Fill the bits above the register width with noise; the block must ignore them.
  function automatic bit [15:0] with_junk(bit [15:0] value, int width);
    bit [15:0] junk;
    junk = 16'($urandom);
    if (width >= 16) return value;
    return ((junk >> width) << width) | value;
  endfunction

  task automatic write_reg(logic [2:0] idx, bit [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_settings(red_settings_t s, bit spare);
    write_reg(REG_QUEUE_CAPACITY,  with_junk(16'(s.capacity), 13));
    write_reg(REG_WEIGHT_SHIFT,    with_junk(16'(s.shift), 4));
    write_reg(REG_MIN_THRESHOLD,   with_junk(16'(s.min_th), 13));
    write_reg(REG_MAX_THRESHOLD,   with_junk(16'(s.max_th), 13));
    write_reg(REG_MAX_PROBABILITY, s.max_p);
    write_reg(REG_ECN_ENABLE,      with_junk(16'(s.ecn), 1));
    if (spare) begin
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic void add_arrival(int qlen, int rnd);
    arrival_t a;
    a.qlen = qlen[12:0];
    a.rnd  = rnd[15:0];
    arrival_q.push_back(a);
  endfunction

  // Arrivals are weighted toward the marking band and the capacity edge.
  function automatic arrival_t random_arrival(red_settings_t s);
    arrival_t a;
    int lo;
    int hi;
    int c;
    int pick;
    lo = int'((s.min_th < s.max_th) ? s.min_th : s.max_th);
    hi = int'((s.min_th < s.max_th) ? s.max_th : s.min_th);
    c  = int'(s.capacity);
    pick = $urandom_range(0, 99);
    if (pick < 50)
      a.qlen = 13'($urandom_range((lo > 4) ? lo - 4 : 0, (hi + 4 > 8191) ? 8191 : hi + 4));
    else if (pick < 70)
      a.qlen = 13'($urandom_range(0, 8191));
    else if (pick < 85)
      a.qlen = 13'($urandom_range((c > 2) ? c - 2 : 0, (c + 2 > 8191) ? 8191 : c + 2));
    else
      a.qlen = 13'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    if (pick == 0)      a.rnd = 16'h0000;
    else if (pick == 1) a.rnd = 16'hFFFF;
    else                a.rnd = 16'($urandom_range(0, 65535));
    return a;
  endfunction

  // Sender: offers the queued arrivals in bursts, with gaps unless steady.
  task automatic send_arrivals(bit steady);
    arrival_t a;
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 12);
    while (arrival_q.size() != 0) begin
      a = arrival_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= {3'b000, a};
      do @(posedge clk); while (in_tready !== 1'b1);
      sb.note_arrival(a.qlen, a.rnd);
      items_sent++;
      burst_left--;
      if (arrival_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!steady && burst_left <= 0) begin
        in_tvalid <= 1'b0;
        gap = $urandom_range(1, 30);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic random_phase(red_settings_t s, int count, bit hold);
    wait_drained();
    apply_settings(s, 1'b0);
    for (int i = 0; i < count; i++) arrival_q.push_back(random_arrival(s));
    if (hold) hold_request = 1'b1;
    send_arrivals(hold || ($urandom_range(0, 3) == 0));
  endtask

  function automatic red_settings_t random_settings();
    red_settings_t s;
    int mn;
    s.capacity = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
                                             : 13'($urandom_range(64, 4096));
    s.shift = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 4))
                                          : 4'($urandom_range(0, 15));
    mn = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8191))
                                     : int'($urandom_range(0, 100));
    s.min_th = mn[12:0];
    s.max_th = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                           : 13'(mn + $urandom_range(1, 100));
    s.max_p = 16'($urandom_range(0, 65535));
    s.ecn   = 1'($urandom_range(0, 1));
    return s;
  endfunction

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of the registers and the state.
    add_arrival(20, 0);
    add_arrival(0, 65535);
    send_arrivals(1'b0);

    // Band 10..20 with the average following the queue exactly, drops on.
    wait_drained();
    apply_settings(make_settings(4096, 0, 10, 20, 32768, 0), 1'b0);
    add_arrival(0, 0);          // below the band
    add_arrival(10, 0);         // average equal to the lower threshold
    add_arrival(11, 65535);     // in band, no mark
    repeat (5) add_arrival(15, 65535);  // count grows until the mark is certain
    add_arrival(20, 0);         // average equal to the upper threshold
    add_arrival(21, 65535);     // above the band
    add_arrival(4096, 0);       // forced drop at capacity, average held
    add_arrival(8191, 0);       // forced drop, largest length
    add_arrival(4095, 0);
    send_arrivals(1'b0);

    // Whole range as band, ECN marking, capacity above the depth.
    wait_drained();
    apply_settings(make_settings(8191, 0, 0, 4096, 65535, 1), 1'b0);
    add_arrival(8191, 0);       // forced drop at the largest capacity
    add_arrival(8190, 100);     // length clamped to the queue depth
    add_arrival(4096, 65535);
    add_arrival(4096, 65535);   // divisor at its least nonzero value, mark is certain
    add_arrival(0, 65535);
    add_arrival(1, 0);
    send_arrivals(1'b0);

    // Inverted thresholds: only the upper threshold matters.
    wait_drained();
    apply_settings(make_settings(4096, 0, 30, 10, 65535, 0), 1'b0);
    add_arrival(20, 0);
    add_arrival(5, 0);
    send_arrivals(1'b0);

    // Zero capacity drops everything; writes past the register list are ignored.
    wait_drained();
    apply_settings(make_settings(0, 15, 20, 20, 0, 1), 1'b1);
    add_arrival(0, 0);
    add_arrival(1, 65535);
    send_arrivals(1'b0);

    // Random traffic over a range of settings.
    random_phase(make_settings(4096, 9, 5, 15, 6554, 0), 150, 1'b0);
    random_phase(make_settings(8191, 0, 0, 4096, 65535, 1), 100, 1'b0);
    random_phase(make_settings(300, 2, 100, 200, 30000, 0), 100, 1'b1);
    random_phase(make_settings(1, 15, 0, 0, 0, 1), 40, 1'b0);
    random_phase(make_settings(4096, 1, 40, 60, 1, 1), 100, 1'b0);
    random_phase(make_settings(6000, 3, 8191, 8191, 65535, 0), 40, 1'b0);
    repeat (4) random_phase(random_settings(), 100, 1'b0);

    // Let the last results drain, then watch for anything extra.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d arrivals under %0d register settings, %0d inside the band.",
             items_sent, settings_used, sb.band_hits);
    $display("Verdicts seen: enqueue %0d, marked %0d, early drop %0d, forced drop %0d.",
             sb.verdict_seen[VERDICT_ENQUEUE], sb.verdict_seen[VERDICT_MARKED],
             sb.verdict_seen[VERDICT_EARLY_DROP], sb.verdict_seen[VERDICT_FORCED_DROP]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[red_enqueue_decision.f]
hdl/red_pkg.sv
hdl/red_enqueue_decision.sv
tb/sv/red_enqueue_decision_tb.sv
